/* src/fpaf_pkg.sv */
// fpaf_pkg: shared constants, widths and the pipeline stage type of the
// fixed-point autorange formatter. No dependencies.
`default_nettype none

package fpaf_pkg;

  // width of the signed input value in hundredths
  localparam int unsigned VALUE_W = 28;
  // magnitude width (holds 2^27 for the most negative input)
  localparam int unsigned MAG_W = VALUE_W;
  // decimal digits needed for the magnitude
  localparam int unsigned NDIG = 9;
  localparam int unsigned BCD_W = 4 * NDIG;

  // characters in the display field
  localparam int unsigned FIELD_CHARS = 4;
  // character ports on the top level
  localparam int unsigned OUT_CHARS = 4;
  localparam int unsigned CHAR_W = 6;
  localparam int unsigned KW = $clog2(FIELD_CHARS);

  // shift-and-add-3 conversion split over equal stages
  localparam int unsigned BCD_STAGES = 4;
  localparam int unsigned STEPS_PER_STAGE = MAG_W / BCD_STAGES;

  // ascii codes, low six bits
  localparam logic [CHAR_W-1:0] CH_ZERO  = 6'h30;
  localparam logic [CHAR_W-1:0] CH_POINT = 6'h2E;
  localparam logic [CHAR_W-1:0] CH_NONE  = 6'h00;

  typedef struct packed {
    logic             valid;
    logic             neg;
    logic [MAG_W-1:0] bin;
    logic [BCD_W-1:0] bcd;
  } stage_t;

endpackage

`default_nettype wire

/* src/fpaf_bcd_stage.sv */
// fpaf_bcd_stage: one registered slice of the shift-and-add-3 binary to
// decimal conversion. Depends on fpaf_pkg.
`default_nettype none

module fpaf_bcd_stage #(
  parameter int unsigned STEPS = fpaf_pkg::STEPS_PER_STAGE
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire fpaf_pkg::stage_t stage_i,
  output fpaf_pkg::stage_t      stage_o
);

  logic [fpaf_pkg::BCD_W-1:0] bcd_d;
  logic [fpaf_pkg::MAG_W-1:0] bin_d;
  logic                       valid_q;
  logic                       neg_q;
  logic [fpaf_pkg::MAG_W-1:0] bin_q;
  logic [fpaf_pkg::BCD_W-1:0] bcd_q;

  always_comb begin
    bcd_d = stage_i.bcd;
    bin_d = stage_i.bin;
    for (int s = 0; s < int'(STEPS); s++) begin
      for (int g = 0; g < int'(fpaf_pkg::NDIG); g++) begin
        if (bcd_d[g*4 +: 4] >= 4'd5) begin
          bcd_d[g*4 +: 4] = bcd_d[g*4 +: 4] + 4'd3;
        end
      end
      {bcd_d, bin_d} = {bcd_d[fpaf_pkg::BCD_W-2:0], bin_d, 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= stage_i.neg;
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign stage_o = '{valid: valid_q, neg: neg_q, bin: bin_q, bcd: bcd_q};

endmodule

`default_nettype wire

/* src/fixed_point_autorange_formatter.sv */
// fixed_point_autorange_formatter: top level, signed hundredths to ascii field.
// Depends on fpaf_pkg and fpaf_bcd_stage.
// Throughput: one transaction per cycle; busy_o stays low, nothing ever stalls.
// The depth is set by the four-slice decimal conversion plus a magnitude
// stage and a formatting stage. Reset clears only the valid bits.
`default_nettype none

module fixed_point_autorange_formatter (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  output logic                                      busy_o,
  input  wire logic signed [fpaf_pkg::VALUE_W-1:0]  value_hundredths_i,
  output logic                                      done_o,
  output logic                                      sign_written_o,
  output logic                                      lead_written_o,
  output logic [fpaf_pkg::CHAR_W-1:0]               char_pos0_o,
  output logic [fpaf_pkg::CHAR_W-1:0]               char_pos1_o,
  output logic [fpaf_pkg::CHAR_W-1:0]               char_pos2_o,
  output logic [fpaf_pkg::CHAR_W-1:0]               char_pos3_o,
  output logic                                      too_large_o
);

  localparam int F = int'(fpaf_pkg::FIELD_CHARS);
  localparam int N = int'(fpaf_pkg::BCD_STAGES);

  // pipeline never stalls, a new transaction may enter every cycle
  assign busy_o = 1'b0;

  // stage 0: sign split and magnitude
  logic                       neg_d;
  logic [fpaf_pkg::MAG_W-1:0] mag_d;
  logic                       s0_valid_q;
  logic                       s0_neg_q;
  logic [fpaf_pkg::MAG_W-1:0] s0_mag_q;
  fpaf_pkg::stage_t           stage_q [N+1];

  assign neg_d = value_hundredths_i[fpaf_pkg::VALUE_W-1];
  // two's complement negate; -2^27 comes out as 2^27 unsigned
  assign mag_d = neg_d ? (fpaf_pkg::MAG_W'(0) - fpaf_pkg::MAG_W'(value_hundredths_i))
                       : fpaf_pkg::MAG_W'(value_hundredths_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_neg_q <= neg_d;
    s0_mag_q <= mag_d;
  end

  assign stage_q[0] = '{valid: s0_valid_q, neg: s0_neg_q, bin: s0_mag_q, bcd: '0};

  // stages 1..4: binary to decimal, a slice of the shifts per stage
  for (genvar i = 0; i < N; i++) begin : g_bcd
    fpaf_bcd_stage #(
      .STEPS (fpaf_pkg::STEPS_PER_STAGE)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (stage_q[i]),
      .stage_o (stage_q[i+1])
    );
  end

  // formatting: digits of the magnitude, point slot from the integer part
  logic [fpaf_pkg::BCD_W-1:0]  bcd_w;
  logic [fpaf_pkg::NDIG:0]     nz_above_w;   // any digit at this index or above
  logic [fpaf_pkg::KW-1:0]     k_w;          // point slot counted from the right
  logic [fpaf_pkg::CHAR_W-1:0] ch_d [fpaf_pkg::OUT_CHARS];
  logic                        lead_d;
  logic                        too_d;

  assign bcd_w = stage_q[N].bcd;

  always_comb begin
    nz_above_w[fpaf_pkg::NDIG] = 1'b0;
    for (int i = int'(fpaf_pkg::NDIG) - 1; i >= 0; i--) begin
      nz_above_w[i] = nz_above_w[i+1] | (bcd_w[i*4 +: 4] != 4'd0);
    end
  end

  // integer part >= 10^(F-1-k) means a nonzero digit at index F+1-k or above
  always_comb begin
    logic found;
    found = 1'b0;
    k_w   = fpaf_pkg::KW'(F - 1);
    for (int kk = 0; kk < F - 1; kk++) begin
      if (!found && nz_above_w[F + 1 - kk]) begin
        k_w   = fpaf_pkg::KW'(kk);
        found = 1'b1;
      end
    end
  end

  assign lead_d = (k_w != fpaf_pkg::KW'(1));
  // integer part above 10^F - 1
  assign too_d  = nz_above_w[F + 2];

  always_comb begin
    int kv;
    int start;
    int used;
    int e;
    kv = int'(k_w);
    start = (kv == 1) ? 1 : 0;
    for (int p = 0; p < int'(fpaf_pkg::OUT_CHARS); p++) begin
      ch_d[p] = fpaf_pkg::CH_NONE;
      used = 0;
      e = 0;
      if (p < F) begin
        if (kv == 1 && p == 0) begin
          // three-digit integer: leading cell left unwritten
          ch_d[p] = fpaf_pkg::CH_NONE;
        end else if (kv != 1 && p == F - kv) begin
          ch_d[p] = fpaf_pkg::CH_POINT;
        end else begin
          used = p - start - ((kv != 1 && p > F - kv) ? 1 : 0);
          e = F + 1 - kv - used;
          if (e < 0) begin
            // places past the hundredths digit
            ch_d[p] = fpaf_pkg::CH_ZERO;
          end else begin
            ch_d[p] = fpaf_pkg::CH_ZERO + {2'b00, bcd_w[e*4 +: 4]};
          end
        end
      end
    end
  end

  // stage 5: result registers, strobe for one cycle
  logic                        done_q;
  logic                        sign_q;
  logic                        lead_q;
  logic                        too_q;
  logic [fpaf_pkg::CHAR_W-1:0] ch_q [fpaf_pkg::OUT_CHARS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= stage_q[N].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    sign_q <= stage_q[N].neg;
    lead_q <= lead_d;
    too_q  <= too_d;
    ch_q   <= ch_d;
  end

  assign done_o         = done_q;
  assign sign_written_o = sign_q;
  assign lead_written_o = lead_q;
  assign too_large_o    = too_q;
  assign char_pos0_o    = ch_q[0];
  assign char_pos1_o    = ch_q[1];
  assign char_pos2_o    = ch_q[2];
  assign char_pos3_o    = ch_q[3];

endmodule

`default_nettype wire
